/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the blob centroid scanner checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CHK_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a signal holds in the cycle after a condition.
`define CHK_STABLE(lbl, clk, rstn, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) cond |=> $stable(sig)) \
        else $error(msg);

`endif

/* hdl/brc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_pkg
// Types and constants shared by the run-length blob centroid scanner.
// ----------------------------------------------------------------------------
package brc_pkg;

    // Position and register widths
    localparam int DIM_W       = 12;
    localparam int SCORE_W     = 14;
    localparam int GRID_X_W    = 8;
    localparam int GRID_Y_W    = 9;
    localparam int GRID_X_SHIFT = 4;
    localparam int CFG_IDX_W   = 2;

    // Largest row/column count supported by default
    localparam int MAX_DIM_DEF = 4096;

    // Scan constants
    localparam logic [7:0]          AVG_LEVEL   = 8'd128;
    localparam logic [DIM_W-1:0]    NO_CENTROID = 12'd400;
    localparam logic [DIM_W-1:0]    LEN_MAX     = 12'd4095;
    localparam logic [3:0]          GRID_Y_DIV  = 4'd12;
    // Grid row of the default centroid (400 / 12)
    localparam logic [GRID_Y_W-1:0] NO_GRID_Y   = 9'd33;

    // Configuration register reset values
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST = 12'd320;
    localparam logic [DIM_W-1:0] ROW_START_RST   = 12'd0;
    localparam logic [DIM_W-1:0] ROW_END_RST     = 12'd240;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_START   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_END     = 2'd2;

    typedef struct packed {
        logic [7:0] pixel;
        logic       first_of_frame;
    } brc_in_t;

    typedef struct packed {
        logic [DIM_W-1:0]    centroid_x;
        logic [DIM_W-1:0]    centroid_y;
        logic [GRID_X_W-1:0] grid_x;
        logic [GRID_Y_W-1:0] grid_y;
        logic [SCORE_W-1:0]  best_score;
    } brc_out_t;

endpackage

/* hdl/blob_run_centroid_scan_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blob_run_centroid_scan_top
// Run-length blob centroid scanner over a binary mask stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_ channel (valid/ready), one per transfer, in raster
//   order; first_of_frame marks column 0 of row 0 and restarts the scan.
//   frame_width, row_start and row_end are written through cfg_we/cfg_index/
//   cfg_wdata while the block is idle.
//   One result leaves on the m_ channel after the last pixel of row
//   row_end-1: centroid, grid cell and best score of the frame.
//   Throughput: one pixel per cycle while s_ready is high; the scan core
//   updates all its state in the cycle of the transfer.
//   The result is registered into the output register, or into the skid
//   entry while the output register still holds an earlier result.
//   The output register plus a one-entry skid buffer keeps s_ready high while
//   a result waits; s_ready drops only while both hold results.
//   Reset (aresetn low, synchronous) loads the register defaults 320/0/240,
//   clears the scan state and empties the output stage.
// ----------------------------------------------------------------------------
module blob_run_centroid_scan_top #(
    parameter int MAX_DIM = brc_pkg::MAX_DIM_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [brc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [brc_pkg::DIM_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  brc_pkg::brc_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output brc_pkg::brc_out_t             m_data
);

    logic               s_xfer, m_xfer, produce, emit;
    brc_pkg::brc_out_t  result;
    logic               out_valid_reg, skid_valid_reg;
    brc_pkg::brc_out_t  out_data_reg, skid_data_reg;

    assign s_ready = !skid_valid_reg;
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = out_valid_reg && m_ready;
    assign produce = s_xfer && emit;

    brc_scan #(
        .MAX_DIM (MAX_DIM)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (s_xfer),
        .in_data   (s_data),
        .emit      (emit),
        .result    (result)
    );

    // Output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_xfer) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= produce;
            end
        end else if (produce) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Move payload alongside the valid bits
    always_ff @(posedge aclk) begin
        if (m_xfer) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (produce) begin
                out_data_reg <= result;
            end
        end else if (produce) begin
            if (out_valid_reg) begin
                skid_data_reg <= result;
            end else begin
                out_data_reg <= result;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* hdl/brc_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_scan
// Per-pixel scan core: box average, run tracking, best-run bookkeeping and
// the configuration registers (written on cfg_we). Scan state advances on each pixel transfer.
// ----------------------------------------------------------------------------
module brc_scan #(
    parameter int MAX_DIM = brc_pkg::MAX_DIM_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [brc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brc_pkg::DIM_W-1:0]         cfg_wdata,
    input  logic                              step,
    input  brc_pkg::brc_in_t                  in_data,
    output logic                              emit,
    output brc_pkg::brc_out_t                 result
);

    localparam int W = brc_pkg::DIM_W;
    localparam logic [W-1:0] POS_MAX = (MAX_DIM < 4096) ? W'(MAX_DIM - 1) : W'(4095);

    // Configuration registers
    logic [W-1:0] frame_width_reg, row_start_reg, row_end_reg;

    // Scan state
    logic [W-1:0]                   col_reg, col_next;
    logic [W-1:0]                   row_reg, row_next;
    logic [3:0]                     rmod_reg, rmod_next;
    logic [brc_pkg::GRID_Y_W-1:0]   rdiv_reg, rdiv_next;
    logic                           row_over_reg, row_over_next;
    logic [7:0]                     win0_reg, win1_reg, win2_reg;
    logic [7:0]                     win0_next, win1_next, win2_next;
    logic                           in_run_reg, in_run_next;
    logic [W-1:0]                   run_len_reg, run_len_next;
    logic [W-1:0]                   prev_len_reg, prev_len_next;
    logic [W-1:0]                   prev2_len_reg, prev2_len_next;
    logic [W-1:0]                   left_reg, left_next;
    logic [brc_pkg::SCORE_W-1:0]    best_sum_reg, best_sum_next;
    logic [W-1:0]                   best_col_reg, best_col_next;
    logic [W-1:0]                   best_row_reg, best_row_next;
    logic [brc_pkg::GRID_Y_W-1:0]   best_gy_reg, best_gy_next;

    // Combinational helpers
    logic                           clear;
    logic [W-1:0]                   col_cur, row_cur, last_col, j_pos;
    logic                           row_over_cur, scanned, row_done;
    logic [9:0]                     box_sum;
    logic [7:0]                     avg;
    logic [brc_pkg::SCORE_W-1:0]    run_sum;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= brc_pkg::FRAME_WIDTH_RST;
            row_start_reg   <= brc_pkg::ROW_START_RST;
            row_end_reg     <= brc_pkg::ROW_END_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                brc_pkg::REG_FRAME_WIDTH: frame_width_reg <= cfg_wdata;
                brc_pkg::REG_ROW_START:   row_start_reg   <= cfg_wdata;
                brc_pkg::REG_ROW_END:     row_end_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Last column of a row, clipped to the counter top
    always_comb begin
        if (frame_width_reg == '0) begin
            last_col = W'(4095);
        end else begin
            last_col = frame_width_reg - W'(1);
        end
        if (last_col > POS_MAX) begin
            last_col = POS_MAX;
        end
    end

    assign clear = in_data.first_of_frame;

    // Compute next scan state for the pixel in flight
    always_comb begin
        // Start of frame restarts everything before the pixel is used
        col_cur        = clear ? '0 : col_reg;
        row_cur        = clear ? '0 : row_reg;
        row_over_cur   = clear ? 1'b0 : row_over_reg;
        rmod_next      = clear ? '0 : rmod_reg;
        rdiv_next      = clear ? '0 : rdiv_reg;
        win0_next      = clear ? '0 : win0_reg;
        win1_next      = clear ? '0 : win1_reg;
        win2_next      = clear ? '0 : win2_reg;
        in_run_next    = clear ? 1'b0 : in_run_reg;
        run_len_next   = clear ? '0 : run_len_reg;
        prev_len_next  = clear ? '0 : prev_len_reg;
        prev2_len_next = clear ? '0 : prev2_len_reg;
        left_next      = clear ? '0 : left_reg;
        best_sum_next  = clear ? '0 : best_sum_reg;
        best_col_next  = clear ? brc_pkg::NO_CENTROID : best_col_reg;
        best_row_next  = clear ? brc_pkg::NO_CENTROID : best_row_reg;
        best_gy_next   = clear ? brc_pkg::NO_GRID_Y : best_gy_reg;
        row_over_next  = row_over_cur;
        row_next       = row_cur;

        // Drop any open run at the first column
        if (col_cur == '0) begin
            in_run_next  = 1'b0;
            run_len_next = '0;
        end

        scanned = !row_over_cur && (row_cur >= row_start_reg)
                  && ((13'(row_cur) + 13'd1) <= 13'(row_end_reg));

        box_sum = 10'(win0_next) + 10'(win1_next) + 10'(win2_next) + 10'(in_data.pixel);
        avg     = box_sum[9:2];
        j_pos   = col_cur - W'(3);
        run_sum = brc_pkg::SCORE_W'(prev2_len_next) + brc_pkg::SCORE_W'(prev_len_next)
                  + brc_pkg::SCORE_W'(run_len_next);

        // Track run edges on the box average
        if (scanned && (col_cur >= W'(3))) begin
            if (!in_run_next && (avg > brc_pkg::AVG_LEVEL)) begin
                in_run_next  = 1'b1;
                run_len_next = '0;
                left_next    = j_pos;
            end else if (in_run_next && (avg < brc_pkg::AVG_LEVEL)) begin
                in_run_next = 1'b0;
                if (run_sum > best_sum_next) begin
                    best_sum_next = run_sum;
                    best_col_next = left_next + ((j_pos - left_next) >> 1);
                    best_row_next = row_cur;
                    best_gy_next  = rdiv_next;
                end
                prev2_len_next = prev_len_next;
                prev_len_next  = run_len_next;
                run_len_next   = '0;
            end else if (in_run_next) begin
                if (run_len_next < brc_pkg::LEN_MAX) begin
                    run_len_next = run_len_next + W'(1);
                end
            end
        end

        // Shift the box window
        win0_next = win1_next;
        win1_next = win2_next;
        win2_next = in_data.pixel;

        // Advance column and row counters
        row_done = (col_cur >= last_col);
        emit     = row_done && !row_over_cur && ((13'(row_cur) + 13'd1) == 13'(row_end_reg));
        if (row_done) begin
            col_next = '0;
            if (row_cur >= POS_MAX) begin
                row_over_next = 1'b1;
            end else begin
                row_next = row_cur + W'(1);
                if (rmod_next == brc_pkg::GRID_Y_DIV - 4'd1) begin
                    rmod_next = '0;
                    rdiv_next = rdiv_next + brc_pkg::GRID_Y_W'(1);
                end else begin
                    rmod_next = rmod_next + 4'd1;
                end
            end
        end else begin
            col_next = col_cur + W'(1);
        end
    end

    // Result fields from the updated best run
    always_comb begin
        result.centroid_x = best_col_next;
        result.centroid_y = best_row_next;
        result.grid_x     = best_col_next[W-1:brc_pkg::GRID_X_SHIFT];
        result.grid_y     = best_gy_next;
        result.best_score = best_sum_next;
    end

    // Hold scan state, advance on each pixel transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            rmod_reg      <= '0;
            rdiv_reg      <= '0;
            row_over_reg  <= 1'b0;
            win0_reg      <= '0;
            win1_reg      <= '0;
            win2_reg      <= '0;
            in_run_reg    <= 1'b0;
            run_len_reg   <= '0;
            prev_len_reg  <= '0;
            prev2_len_reg <= '0;
            left_reg      <= '0;
            best_sum_reg  <= '0;
            best_col_reg  <= brc_pkg::NO_CENTROID;
            best_row_reg  <= brc_pkg::NO_CENTROID;
            best_gy_reg   <= brc_pkg::NO_GRID_Y;
        end else if (step) begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            rmod_reg      <= rmod_next;
            rdiv_reg      <= rdiv_next;
            row_over_reg  <= row_over_next;
            win0_reg      <= win0_next;
            win1_reg      <= win1_next;
            win2_reg      <= win2_next;
            in_run_reg    <= in_run_next;
            run_len_reg   <= run_len_next;
            prev_len_reg  <= prev_len_next;
            prev2_len_reg <= prev2_len_next;
            left_reg      <= left_next;
            best_sum_reg  <= best_sum_next;
            best_col_reg  <= best_col_next;
            best_row_reg  <= best_row_next;
            best_gy_reg   <= best_gy_next;
        end
    end

endmodule

/* hdl/brc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_checker
// Port-level checks on the blob centroid scanner result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brc_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  brc_pkg::brc_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  brc_pkg::brc_out_t m_data
);

    logic m_stall;
    logic s_seen;

    assign m_stall = m_valid && !m_ready;
    assign s_seen  = s_valid && s_ready && s_data.first_of_frame;

    // Hold a stalled result
    `CHK_PROP(a_m_valid_hold, aclk, aresetn, m_stall |=> m_valid, "result dropped while stalled")
    `CHK_STABLE(a_m_data_hold, aclk, aresetn, m_stall, m_data, "result changed while stalled")

    // Grid cells follow the centroid
    `CHK_PROP(a_grid_x, aclk, aresetn, m_valid |-> (m_data.grid_x == m_data.centroid_x[11:4]), "grid_x mismatch")
    `CHK_PROP(a_grid_y, aclk, aresetn, m_valid |-> ((13'(m_data.grid_y) * 13'd12 <= 13'(m_data.centroid_y)) && (13'(m_data.centroid_y) < 13'(m_data.grid_y) * 13'd12 + 13'd12)), "grid_y mismatch")

    // No winning run means the default centroid
    `CHK_PROP(a_no_run, aclk, aresetn, (m_valid && (m_data.best_score == 14'd0)) |-> ((m_data.centroid_x == 12'd400) && (m_data.centroid_y == 12'd400) && (s_seen || !s_seen)), "default centroid expected")

endmodule

bind blob_run_centroid_scan_top brc_checker u_brc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/sv/tb_blob_run_centroid_scan_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blob_run_centroid_scan_top
// Self-checking bench for the run-length blob centroid scanner.
// ----------------------------------------------------------------------------
// Mask pixels are queued by the stimulus thread and sent by a valid/ready
// driver with random gaps. The result side stalls at random. Every accepted
// pixel runs through a scan predictor kept in the bench. The predictor pushes
// the expected centroid whenever a pixel closes the last scanned row, and
// each received result is compared field by field with the oldest one.
// Stimulus: a short directed frame set (average on the level, runs carried
// across rows, narrow rows, empty scan range, zero row_end). Then random
// frames under many register settings, broken and continued frames among
// them. Last come the widest row settings, each frame cut after a few pixels.
// ----------------------------------------------------------------------------
module tb_blob_run_centroid_scan_top;

    localparam int CLK_PERIOD  = 12;
    localparam int RAND_PIXELS = 1560;
    localparam logic [brc_pkg::DIM_W-1:0] ROW_TOP = 12'd4095;
    // Index 3 is not decoded by the block; writes there must change nothing
    localparam logic [brc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [brc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [brc_pkg::DIM_W-1:0]     cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    brc_pkg::brc_in_t              s_data = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    brc_pkg::brc_out_t             m_data;

    blob_run_centroid_scan_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // Pixels waiting to be sent and centroids waiting to arrive
    brc_pkg::brc_in_t  pixel_q[$];
    brc_pkg::brc_out_t centroid_q[$];

    int  mismatch_cnt = 0;
    int  px_queued = 0;
    int  px_sent = 0;
    int  results_due = 0;
    int  results_seen = 0;
    int  reg_writes = 0;
    bit  px_taken = 1'b0;
    bit  res_taken = 1'b0;
    bit  src_quiet = 1'b0;
    bit  snk_quiet = 1'b0;
    bit  sink_armed = 1'b0;
    int  src_gap = 0;
    int  sink_gap = 0;

    // ------------------------------------------------------------------
    // Scan predictor: registers and scan state
    // ------------------------------------------------------------------
    logic [brc_pkg::DIM_W-1:0]   fw_reg, rs_reg, re_reg;
    logic [brc_pkg::DIM_W-1:0]   col_pos, row_pos;
    bit                          row_over;
    logic [7:0]                  win [0:2];
    bit                          run_open;
    logic [brc_pkg::DIM_W-1:0]   run_len, run_len_1, run_len_2, run_left;
    logic [brc_pkg::SCORE_W-1:0] top_sum;
    logic [brc_pkg::DIM_W-1:0]   top_col, top_row;

    function automatic void clear_scan_state();
        col_pos   = '0;
        row_pos   = '0;
        row_over  = 1'b0;
        win[0]    = '0;
        win[1]    = '0;
        win[2]    = '0;
        run_open  = 1'b0;
        run_len   = '0;
        run_len_1 = '0;
        run_len_2 = '0;
        run_left  = '0;
        top_sum   = '0;
        top_col   = brc_pkg::NO_CENTROID;
        top_row   = brc_pkg::NO_CENTROID;
    endfunction

    // Advance the scan by one pixel; queue a centroid when the last scanned
    // row closes
    task automatic scan_pixel(input brc_pkg::brc_in_t it);
        logic [brc_pkg::DIM_W-1:0]   c, r, last_c, j;
        logic [9:0]                  avg_sum;
        logic [7:0]                  avg;
        logic [brc_pkg::SCORE_W-1:0] tri_sum;
        bit                          scan_on, fire;
        brc_pkg::brc_out_t           res;

        if (it.first_of_frame) clear_scan_state();
        c = col_pos;
        r = row_pos;
        // width 0 wraps to a last column of 4095, i.e. 4096 pixels
        last_c = fw_reg - 12'd1;

        // Drop any run left open by the previous row
        if (c == '0) begin
            run_open = 1'b0;
            run_len  = '0;
        end

        scan_on = !row_over && r >= rs_reg && r < re_reg;
        if (scan_on && c >= 12'd3) begin
            avg_sum = {2'b0, win[0]} + {2'b0, win[1]} + {2'b0, win[2]} + {2'b0, it.pixel};
            avg = avg_sum[9:2];
            j = c - 12'd3;
            if (!run_open && avg > brc_pkg::AVG_LEVEL) begin
                run_open = 1'b1;
                run_len  = '0;
                run_left = j;
            end else if (run_open && avg < brc_pkg::AVG_LEVEL) begin
                run_open = 1'b0;
                tri_sum = {2'b0, run_len_2} + {2'b0, run_len_1} + {2'b0, run_len};
                if (tri_sum > top_sum) begin
                    top_sum = tri_sum;
                    top_col = run_left + ((j - run_left) >> 1);
                    top_row = r;
                end
                run_len_2 = run_len_1;
                run_len_1 = run_len;
                run_len   = '0;
            end else if (run_open) begin
                if (run_len < brc_pkg::LEN_MAX) run_len = run_len + 12'd1;
            end
        end

        win[0] = win[1];
        win[1] = win[2];
        win[2] = it.pixel;

        // Advance position; hold the row counter at its top value
        fire = 1'b0;
        if (c >= last_c) begin
            fire = !row_over && ({1'b0, r} + 13'd1 == {1'b0, re_reg});
            col_pos = '0;
            if (r >= ROW_TOP) row_over = 1'b1;
            else row_pos = r + 12'd1;
        end else begin
            col_pos = c + 12'd1;
        end

        if (fire) begin
            res.centroid_x = top_col;
            res.centroid_y = top_row;
            res.grid_x     = brc_pkg::GRID_X_W'(top_col >> brc_pkg::GRID_X_SHIFT);
            res.grid_y     = brc_pkg::GRID_Y_W'(top_row / brc_pkg::GRID_Y_DIV);
            res.best_score = top_sum;
            centroid_q.push_back(res);
            results_due++;
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 40) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_centroid(input brc_pkg::brc_out_t got);
        brc_pkg::brc_out_t want;

        if (centroid_q.size() == 0) begin
            report_mismatch($sformatf("result %0d,%0d score %0d with none pending",
                                      got.centroid_x, got.centroid_y, got.best_score));
            return;
        end
        want = centroid_q.pop_front();
        if (got.centroid_x != want.centroid_x)
            report_mismatch($sformatf("centroid_x %0d, expected %0d",
                                      got.centroid_x, want.centroid_x));
        if (got.centroid_y != want.centroid_y)
            report_mismatch($sformatf("centroid_y %0d, expected %0d",
                                      got.centroid_y, want.centroid_y));
        if (got.grid_x != want.grid_x)
            report_mismatch($sformatf("grid_x %0d, expected %0d", got.grid_x, want.grid_x));
        if (got.grid_y != want.grid_y)
            report_mismatch($sformatf("grid_y %0d, expected %0d", got.grid_y, want.grid_y));
        if (got.best_score != want.best_score)
            report_mismatch($sformatf("best_score %0d, expected %0d",
                                      got.best_score, want.best_score));
    endtask

    // Observe transfers on both channels; predict before checking
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                scan_pixel(s_data);
                px_sent++;
                px_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                check_centroid(m_data);
                results_seen++;
                res_taken = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel driver: random gap after each transfer
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || px_taken) begin
            if (px_taken) src_gap = src_quiet ? 0 : $urandom_range(0, 8);
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                s_data  <= pixel_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        px_taken = 1'b0;
    end

    // ------------------------------------------------------------------
    // Result sink: draw a stall for each result as it shows up
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (res_taken) sink_armed = 1'b0;
            if (m_valid && !sink_armed) begin
                sink_gap   = snk_quiet ? 0 : $urandom_range(0, 8);
                sink_armed = 1'b1;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
        res_taken = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [brc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [brc_pkg::DIM_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            brc_pkg::REG_FRAME_WIDTH: fw_reg = val;
            brc_pkg::REG_ROW_START:   rs_reg = val;
            brc_pkg::REG_ROW_END:     re_reg = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic push_px(input logic [7:0] pixel, input bit first);
        brc_pkg::brc_in_t it;

        it.pixel          = pixel;
        it.first_of_frame = first;
        pixel_q.push_back(it);
        px_queued++;
    endtask

    // Mostly clean mask values, some noise and some values near the level
    function automatic logic [7:0] mask_value(input bit obj);
        case ($urandom_range(0, 15))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'($urandom_range(124, 136));
            default: return obj ? 8'd255 : 8'd0;
        endcase
    endfunction

    // Queue rows of alternating object and background segments; cut stops
    // the frame early (negative: never), noisy adds stray frame restarts
    task automatic queue_frame(input int n_rows, input int width, input int seg_max,
                               input int cut, input bit restart, input bit noisy);
        int r, c, seg_left, n;
        bit obj, first;

        n = 0;
        for (r = 0; r < n_rows; r++) begin
            obj = $urandom_range(0, 1);
            seg_left = $urandom_range(1, seg_max);
            for (c = 0; c < width; c++) begin
                if (n == cut) return;
                if (seg_left == 0) begin
                    obj = !obj;
                    seg_left = $urandom_range(1, seg_max);
                end
                first = (restart && n == 0) || (noisy && $urandom_range(0, 299) == 0);
                push_px(mask_value(obj), first);
                seg_left--;
                n++;
            end
        end
    endtask

    // Let all queued pixels go out and all pending centroids arrive
    task automatic wait_drained();
        int n;
        brc_pkg::brc_out_t lost;

        n = 0;
        while (pixel_q.size() != 0 || s_valid) @(posedge aclk);
        while (centroid_q.size() != 0 && n < 400) begin
            @(posedge aclk);
            n++;
        end
        while (centroid_q.size() != 0) begin
            lost = centroid_q.pop_front();
            report_mismatch($sformatf("missing result %0d,%0d score %0d",
                                      lost.centroid_x, lost.centroid_y, lost.best_score));
        end
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] two_rows [0:15] = '{8'd255, 8'd255, 8'd255, 8'd255,
                                        8'd0,   8'd0,   8'd0,   8'd0,
                                        8'd128, 8'd128, 8'd128, 8'd128,
                                        8'd132, 8'd132, 8'd120, 8'd120};
        int fw, rs, re, rows, n_frames, f, cut, px_base, due_base;

        fw_reg = brc_pkg::FRAME_WIDTH_RST;
        rs_reg = brc_pkg::ROW_START_RST;
        re_reg = brc_pkg::ROW_END_RST;
        clear_scan_state();

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Run closed in row 0, then a run in row 1 whose average sits on the
        // level for a while; the three-run sum carries across the rows
        cfg_write(brc_pkg::REG_FRAME_WIDTH, 12'd8);
        cfg_write(brc_pkg::REG_ROW_START, 12'd0);
        cfg_write(brc_pkg::REG_ROW_END, 12'd2);
        for (int i = 0; i < 16; i++) push_px(two_rows[i], i == 0);
        wait_drained();

        // Rows under four pixels give no average at all
        cfg_write(brc_pkg::REG_FRAME_WIDTH, 12'd3);
        cfg_write(brc_pkg::REG_ROW_END, 12'd1);
        push_px(8'd255, 1'b1);
        push_px(8'd255, 1'b0);
        push_px(8'd255, 1'b0);
        wait_drained();

        // One-pixel frames back to back: a result per pixel
        cfg_write(brc_pkg::REG_FRAME_WIDTH, 12'd1);
        push_px(8'd255, 1'b1);
        push_px(8'd0, 1'b1);
        push_px(8'd128, 1'b1);
        wait_drained();

        // Empty scan range still reports at the end of row row_end-1
        cfg_write(brc_pkg::REG_ROW_START, 12'd4095);
        cfg_write(brc_pkg::REG_ROW_END, 12'd2);
        push_px(8'd255, 1'b1);
        push_px(8'd255, 1'b0);
        wait_drained();

        // Zero row_end never reports; the spare index is ignored
        cfg_write(brc_pkg::REG_ROW_END, 12'd0);
        cfg_write(REG_SPARE, 12'hFFF);
        push_px(8'd255, 1'b1);
        push_px(8'd255, 1'b0);
        push_px(8'd255, 1'b0);
        wait_drained();

        // Random frames under changing register settings
        px_base  = px_queued;
        due_base = results_due;
        while (px_queued - px_base < RAND_PIXELS || results_due - due_base < 36) begin
            wait_drained();
            case ($urandom_range(0, 9))
                0:       fw = $urandom_range(1, 3);
                1:       fw = $urandom_range(17, 40);
                default: fw = $urandom_range(4, 16);
            endcase
            rs = $urandom_range(0, 2);
            case ($urandom_range(0, 11))
                0:       re = 0;
                1:       re = $urandom_range(0, rs);
                default: re = rs + $urandom_range(1, 4);
            endcase
            src_quiet = ($urandom_range(0, 3) == 0);
            snk_quiet = ($urandom_range(0, 3) == 0);
            cfg_write(brc_pkg::REG_FRAME_WIDTH, brc_pkg::DIM_W'(fw));
            cfg_write(brc_pkg::REG_ROW_START, brc_pkg::DIM_W'(rs));
            cfg_write(brc_pkg::REG_ROW_END, brc_pkg::DIM_W'(re));

            n_frames = $urandom_range(2, 5);
            for (f = 0; f < n_frames; f++) begin
                if (re == 0) rows = $urandom_range(1, 3);
                else rows = re + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, rows * fw) : -1;
                queue_frame(rows, fw, fw / 2 + 1, cut, $urandom_range(0, 9) != 0, 1'b1);
            end
        end

        // Widest rows: 4095 pixels, then width 0 meaning 4096; the row never
        // closes, so no result may appear
        wait_drained();
        src_quiet = 1'b0;
        snk_quiet = 1'b0;
        cfg_write(brc_pkg::REG_FRAME_WIDTH, 12'd4095);
        cfg_write(brc_pkg::REG_ROW_START, 12'd0);
        cfg_write(brc_pkg::REG_ROW_END, 12'd1);
        queue_frame(1, 4095, 8, 20, 1'b1, 1'b0);
        wait_drained();
        cfg_write(brc_pkg::REG_FRAME_WIDTH, 12'd0);
        queue_frame(1, 4096, 8, 20, 1'b1, 1'b0);
        wait_drained();
        repeat (8) @(posedge aclk);

        $display("summary: %0d pixels sent under %0d register writes, %0d results received",
                 px_sent, reg_writes, results_seen);
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(CLK_PERIOD * 600000);
        $display("timeout: %0d pixels sent, %0d queued", px_sent, px_queued);
        $display("status: fail");
        $finish;
    end

endmodule
